// ----- design/indexed_array_list_top_macros.svh -----
// Assertion macros for the indexed array list block.
`ifndef INDEXED_ARRAY_LIST_TOP_MACROS_SVH
`define INDEXED_ARRAY_LIST_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define IAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define IAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IAL_ASSERT_IMP(lbl, ante, cons, msg)

`define IAL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- design/ial_pkg.sv -----
// Package: types, codes and helpers shared by the indexed array list block.
package ial_pkg;

  localparam int IAL_CAPACITY = 128;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         position;
    logic signed [31:0] value;
  } ial_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
    logic               is_empty_flag;
    logic               is_full_flag;
    logic [31:0]        inserts_done;
    logic [31:0]        deletes_done;
  } ial_out_t;

  typedef struct packed {
    logic               ins;
    logic               del;
    logic               load_tap;
    logic               shift_tap;
    logic [7:0]         pos;
    logic signed [31:0] value;
  } ial_cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ial_state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

// ----- design/indexed_array_list_top.sv -----
// Top level: ordered list of signed entries with insert, append, delete and read at index.
//
// The list lives in a row of CAPACITY cells, one entry each; an insert or delete moves every
// later entry by one cell in the same register update. Insert, append and any failed action
// write their result directly, so such items can be accepted back to back. A read or delete
// at position p loads a tap chain from all cells and walks it down one cell per cycle;
// no new item is accepted until the scan ends. The result sits in an output register; the next
// item is taken as soon as that register is free or being drained.
`include "indexed_array_list_top_macros.svh"

module indexed_array_list_top #(
  parameter int CAPACITY = ial_pkg::IAL_CAPACITY
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ial_pkg::ial_in_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output ial_pkg::ial_out_t out_item
);
  import ial_pkg::*;

  localparam logic [7:0] CAP_W = 8'(CAPACITY);

  ial_state_t    state_r, state_nxt;
  logic [7:0]    occ_r, occ_nxt;
  logic [31:0]   ins_r, ins_nxt;
  logic [31:0]   del_r, del_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  ial_out_t      out_r, out_nxt;
  ial_cell_ctl_t ctl;
  logic          in_acc;
  logic          out_free;
  logic          full;
  logic          res_now;
  logic          scan_done;
  logic [1:0]    res_status;

  logic signed [31:0] ent [CAPACITY];
  logic signed [31:0] tap [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] lower_e;
    logic signed [31:0] upper_e;
    logic signed [31:0] upper_t;
    if (g == 0) begin : g_lo
      assign lower_e = '0;
    end else begin : g_lo
      assign lower_e = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign upper_e = '0;
      assign upper_t = '0;
    end else begin : g_hi
      assign upper_e = ent[g+1];
      assign upper_t = tap[g+1];
    end
    ial_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (8'(g)),
      .lower_ent (lower_e),
      .upper_ent (upper_e),
      .upper_tap (upper_t),
      .ent_r     (ent[g]),
      .tap_r     (tap[g])
    );
  end

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign full      = occ_r >= CAP_W;
  assign scan_done = (state_r == S_SCAN) && (cnt_r == 8'd0) && out_free;

  always_comb begin
    ctl        = '0;
    ctl.pos    = in_item.position;
    ctl.value  = in_item.value;
    occ_nxt    = occ_r;
    ins_nxt    = ins_r;
    del_nxt    = del_r;
    cnt_nxt    = cnt_r;
    res_now    = 1'b0;
    res_status = ST_OK;
    if (in_acc) begin
      case (in_item.action)
        ACT_INSERT, ACT_APPEND: begin
          res_now = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else if ((in_item.action == ACT_INSERT) && (in_item.position > occ_r)) begin
            res_status = ST_RANGE;
          end else begin
            ctl.ins = 1'b1;
            if (in_item.action == ACT_APPEND) begin
              ctl.pos = occ_r;
            end
            occ_nxt = occ_r + 8'd1;
            ins_nxt = sat_inc(ins_r);
          end
        end
        ACT_DELETE, ACT_READ: begin
          if (in_item.position >= occ_r) begin
            res_now    = 1'b1;
            res_status = ST_RANGE;
          end else begin
            ctl.load_tap = 1'b1;
            cnt_nxt      = in_item.position;
            if (in_item.action == ACT_DELETE) begin
              ctl.del = 1'b1;
              occ_nxt = occ_r - 8'd1;
              del_nxt = sat_inc(del_r);
            end
          end
        end
        default: ;
      endcase
    end else if ((state_r == S_SCAN) && (cnt_r != 8'd0)) begin
      ctl.shift_tap = 1'b1;
      cnt_nxt       = cnt_r - 8'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (ctl.load_tap) state_nxt = S_SCAN;
      S_SCAN: if (scan_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_now || scan_done) begin
      out_valid_nxt         = 1'b1;
      out_nxt.read_value    = scan_done ? tap[0] : 32'sd0;
      out_nxt.status        = res_status;
      out_nxt.entry_count   = occ_nxt;
      out_nxt.is_empty_flag = (occ_nxt == 8'd0);
      out_nxt.is_full_flag  = (occ_nxt >= CAP_W);
      out_nxt.inserts_done  = ins_nxt;
      out_nxt.deletes_done  = del_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      ins_r       <= '0;
      del_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      ins_r       <= ins_nxt;
      del_r       <= del_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `IAL_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= CAP_W, "occupancy above capacity")
  `IAL_ASSERT_IMP(a_no_take_in_scan, state_r == S_SCAN, !in_ready, "item taken during scan")
  `IAL_ASSERT_NXT(a_scan_count, (state_r == S_SCAN) && (cnt_r != 8'd0), cnt_r == $past(cnt_r) - 8'd1, "scan count not stepping")
  `IAL_ASSERT_NXT(a_ins_grows, ctl.ins, occ_r == $past(occ_r) + 8'd1, "insert did not grow list")

endmodule

// ----- design/ial_cell.sv -----
// One list slot: holds an entry and a read tap, shifts with its neighbors.
module ial_cell (
  input  logic                  clk,
  input  ial_pkg::ial_cell_ctl_t ctl,
  input  logic [7:0]            cell_idx,
  input  logic signed [31:0]    lower_ent,
  input  logic signed [31:0]    upper_ent,
  input  logic signed [31:0]    upper_tap,
  output logic signed [31:0]    ent_r,
  output logic signed [31:0]    tap_r
);
  import ial_pkg::*;

  logic signed [31:0] ent_nxt;
  logic signed [31:0] tap_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (cell_idx > ctl.pos) begin
        ent_nxt = lower_ent;
      end else if (cell_idx == ctl.pos) begin
        ent_nxt = ctl.value;
      end
    end else if (ctl.del && (cell_idx >= ctl.pos)) begin
      ent_nxt = upper_ent;
    end
  end

  always_comb begin
    tap_nxt = tap_r;
    if (ctl.load_tap) begin
      tap_nxt = ent_r;
    end else if (ctl.shift_tap) begin
      tap_nxt = upper_tap;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    tap_r <= tap_nxt;
  end

endmodule

// ----- verif/tb_indexed_array_list_top.sv -----
// Testbench for indexed_array_list_top: random and directed list actions checked against a scoreboard.
`timescale 1ns / 1ps

module tb_indexed_array_list_top;
  import ial_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 400;

  class ial_list_scoreboard;
    logic signed [31:0] entries [IAL_CAPACITY];
    int                 occupancy;
    logic [31:0]        insert_total;
    logic [31:0]        delete_total;
    ial_out_t           expected_q [$];
    int                 mismatches;

    function new();
      occupancy    = 0;
      insert_total = '0;
      delete_total = '0;
      mismatches   = 0;
    endfunction

    function void note_item(ial_in_t it);
      ial_out_t r;
      int       i;
      r = '0;
      r.status = ST_OK;
      if (it.action == ACT_INSERT || it.action == ACT_APPEND) begin
        if (occupancy >= IAL_CAPACITY) begin
          r.status = ST_FULL;
        end else if (it.action == ACT_INSERT && int'(it.position) > occupancy) begin
          r.status = ST_RANGE;
        end else begin
          i = (it.action == ACT_APPEND) ? occupancy : int'(it.position);
          for (int k = occupancy; k > i; k--) entries[k] = entries[k - 1];
          entries[i] = it.value;
          occupancy++;
          if (insert_total != 32'hFFFF_FFFF) insert_total++;
        end
      end else if (int'(it.position) >= occupancy) begin
        r.status = ST_RANGE;
      end else begin
        r.read_value = entries[it.position];
        if (it.action == ACT_DELETE) begin
          for (int k = it.position; k + 1 < occupancy; k++) entries[k] = entries[k + 1];
          occupancy--;
          if (delete_total != 32'hFFFF_FFFF) delete_total++;
        end
      end
      r.entry_count   = occupancy[7:0];
      r.is_empty_flag = (occupancy == 0);
      r.is_full_flag  = (occupancy >= IAL_CAPACITY);
      r.inserts_done  = insert_total;
      r.deletes_done  = delete_total;
      expected_q.push_back(r);
    endfunction

    function string show(ial_out_t r);
      return $sformatf("rd=%0d st=%0d cnt=%0d empty=%0b full=%0b ins=%0d del=%0d",
                       r.read_value, r.status, r.entry_count, r.is_empty_flag,
                       r.is_full_flag, r.inserts_done, r.deletes_done);
    endfunction

    function void check_result(ial_out_t got);
      ial_out_t exp_r;
      mismatches++;
      if (expected_q.size() == 0) begin
        if (mismatches <= 10) $display("ERROR: unexpected result item: %s", show(got));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.read_value != exp_r.read_value || got.status != exp_r.status ||
          got.entry_count != exp_r.entry_count || got.is_empty_flag != exp_r.is_empty_flag ||
          got.is_full_flag != exp_r.is_full_flag || got.inserts_done != exp_r.inserts_done ||
          got.deletes_done != exp_r.deletes_done) begin
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  expected: %s", show(exp_r));
          $display("  actual:   %s", show(got));
        end
        return;
      end
      mismatches--;
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ial_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  ial_out_t out_item;

  ial_list_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int quiet_cycles;

  indexed_array_list_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(ial_in_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic send_op(logic [1:0] act, logic [7:0] pos, logic [31:0] val);
    ial_in_t it;
    it.action   = act;
    it.position = pos;
    it.value    = val;
    send_item(it);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic ial_in_t pick_item(bit grow);
    ial_in_t it;
    int      occ;
    int      r;
    occ         = sb.occupancy;
    r           = $urandom_range(0, 99);
    it.value    = pick_value();
    it.position = 8'($urandom_range(0, 255));
    it.action   = 2'($urandom_range(0, 3));
    if (r < 8) return it;
    if (occ >= IAL_CAPACITY && r < 30) begin
      it.action = $urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND;
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < 25) it.action = ACT_READ;
    else if ((r < 85) == grow) it.action = $urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND;
    else it.action = ACT_DELETE;
    if (it.action == ACT_INSERT) it.position = 8'($urandom_range(0, occ));
    else if (it.action != ACT_APPEND && occ > 0) it.position = 8'($urandom_range(0, occ - 1));
    return it;
  endfunction

  // receiver: random stalls plus one long hold on request
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        hold_left = LONG_HOLD;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit grow;
    sb           = new();
    tx_idle_pct  = 14;
    rx_idle_pct  = 56;
    hold_req     = 1'b0;
    grow         = 1'b1;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_ready <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(ACT_READ,   8'd0,   32'd1);
    send_op(ACT_DELETE, 8'd0,   32'd2);
    send_op(ACT_INSERT, 8'd1,   32'd3);
    send_op(ACT_INSERT, 8'd0,   32'h7FFF_FFFF);
    send_op(ACT_APPEND, 8'd255, 32'h8000_0000);
    send_op(ACT_INSERT, 8'd2,   32'h0000_0000);
    send_op(ACT_INSERT, 8'd1,   32'hFFFF_FFFF);
    send_op(ACT_INSERT, 8'd255, 32'd5);
    send_op(ACT_READ,   8'd0,   32'd0);
    send_op(ACT_READ,   8'd3,   32'd0);
    send_op(ACT_READ,   8'd4,   32'd0);
    send_op(ACT_READ,   8'd255, 32'd0);
    send_op(ACT_DELETE, 8'd255, 32'd0);
    send_op(ACT_DELETE, 8'd1,   32'd0);
    send_op(ACT_READ,   8'd1,   32'd0);
    send_op(ACT_DELETE, 8'd2,   32'd0);
    send_op(ACT_DELETE, 8'd0,   32'd0);
    send_op(ACT_READ,   8'd0,   32'd0);
    send_op(ACT_DELETE, 8'd0,   32'd0);
    send_op(ACT_APPEND, 8'd0,   32'h5555_5555);
    send_op(ACT_APPEND, 8'd170, 32'hAAAA_AAAA);
    send_op(ACT_DELETE, 8'd4,   32'd0);
    send_op(ACT_READ,   8'd1,   32'd0);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 56 : 0;
      rx_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 14 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 100) hold_req = 1'b1;
        if (sb.occupancy >= IAL_CAPACITY) grow = 1'b0;
        else if (sb.occupancy == 0) grow = 1'b1;
        send_item(pick_item(grow));
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (IAL_CAPACITY + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
